>>> design/cfa_pkg.sv
package cfa_pkg;

   localparam int DEF_CELLS      = 1024;
   localparam int DEF_OWNER_BITS = 16;

   localparam int OP_W     = 1;
   localparam int OWNER_W  = 16;
   localparam int LEN_W    = 11;
   localparam int STAT_W   = 2;
   localparam int START_W  = 10;
   localparam int POLICY_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_CLEAR = 1'b1;

   localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_HOLE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD     = 2'd2;

   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   typedef struct packed {
      logic                clear;
      logic                step;
      logic                free;
      logic [POLICY_W-1:0] policy;
   } scan_ctrl_type;

endpackage

>>> design/cfa_cell_mem.sv
module cfa_cell_mem #(
   parameter int DEPTH = cfa_pkg::DEF_CELLS,
   parameter int WIDTH = cfa_pkg::DEF_OWNER_BITS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import cfa_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cfa_hole_unit.sv
module cfa_hole_unit #(
   parameter int CELLS = cfa_pkg::DEF_CELLS,
   parameter int AW    = $clog2(CELLS),
   parameter int CW    = $clog2(CELLS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfa_pkg::scan_ctrl_type ctrl,
   input  logic [AW-1:0]         cell_idx,
   input  logic [CW-1:0]         need,
   output logic                  pick_have,
   output logic [AW-1:0]         pick_start
);
   import cfa_pkg::*;

   logic          have_ff, have_in;
   logic [AW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] pick_start_ff, pick_start_in;
   logic [CW-1:0] pick_len_ff, pick_len_in;
   logic          fits;
   logic          wins;

   assign fits = run_len_ff >= need;
   assign wins = !have_ff
              || (ctrl.policy == POL_BEST  && run_len_ff < pick_len_ff)
              || (ctrl.policy == POL_WORST && run_len_ff > pick_len_ff);

   always_comb begin
      have_in       = have_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      if (ctrl.clear) begin
         have_in    = 1'b0;
         run_len_in = '0;
      end else if (ctrl.step) begin
         if (ctrl.free) begin
            if (run_len_ff == '0) begin
               run_start_in = cell_idx;
            end
            run_len_in = run_len_ff + CW'(1);
         end else begin
            if (fits && wins) begin
               have_in       = 1'b1;
               pick_start_in = run_start_ff;
               pick_len_in   = run_len_ff;
            end
            run_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         run_len_ff <= '0;
      end else begin
         have_ff    <= have_in;
         run_len_ff <= run_len_in;
      end
   end

   always_ff @(posedge clock) begin
      run_start_ff  <= run_start_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
   end

   assign pick_have  = have_ff;
   assign pick_start = pick_start_ff;

endmodule

>>> design/contiguous_fit_allocator_top.sv
// Channel  Direction  Handshake               Word
// req      in         start & !busy           req_op, req_owner, req_run_length
// rsp      out        rsp_valid, one cycle    rsp_status, rsp_start_cell
// csr      in         csr_valid & csr_ready   csr_fit_policy
//
// After reset a clearing pass writes every cell free, with busy high.
// Bad requests and allocations longer than CELLS answer in the cycle after acceptance, without a scan.
// Other requests scan with one memory read per cell, then drain and decide; a successful
// allocation then writes run_length cells with the owner.
// The response is a one-cycle strobe; the receiver cannot stall it.
module contiguous_fit_allocator_top #(
   parameter int CELLS      = cfa_pkg::DEF_CELLS,
   parameter int OWNER_BITS = cfa_pkg::DEF_OWNER_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cfa_pkg::OP_W-1:0]      req_op,
   input  logic [cfa_pkg::OWNER_W-1:0]   req_owner,
   input  logic [cfa_pkg::LEN_W-1:0]     req_run_length,
   output logic                          rsp_valid,
   output logic [cfa_pkg::STAT_W-1:0]    rsp_status,
   output logic [cfa_pkg::START_W-1:0]   rsp_start_cell,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cfa_pkg::POLICY_W-1:0]  csr_fit_policy
);
   import cfa_pkg::*;

   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(CELLS + 1);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_FILL   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [CW-1:0]         need_ff, need_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic                  chk_last_ff, chk_last_in;
   logic [AW-1:0]         chk_idx_ff, chk_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [POLICY_W-1:0]   policy_ff;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [OWNER_BITS-1:0] mem_wdata;
   logic                  mem_re;
   logic [OWNER_BITS-1:0] mem_rdata;

   scan_ctrl_type         scan_ctrl;
   logic                  scan_clear;
   logic                  scan_step;
   logic                  scan_free;
   logic                  pick_have;
   logic [AW-1:0]         pick_start;

   logic [OWNER_BITS+OWNER_W-1:0] owner_ext;
   logic [OWNER_BITS-1:0]         owner_req;
   logic [31:0]                   len_ext;
   logic [AW+START_W-1:0]         start_ext;

   assign owner_ext = {{OWNER_BITS{1'b0}}, req_owner};
   assign owner_req = owner_ext[OWNER_BITS-1:0];
   assign len_ext   = {{(32-LEN_W){1'b0}}, req_run_length};
   assign start_ext = {{START_W{1'b0}}, pick_start};

   cfa_cell_mem #(
      .DEPTH (CELLS),
      .WIDTH (OWNER_BITS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign scan_step = chk_valid_ff && (op_ff == OP_ALLOC);
   assign scan_free = !chk_last_ff && (mem_rdata == '0);
   assign scan_ctrl = {scan_clear, scan_step, scan_free, policy_ff};

   cfa_hole_unit #(
      .CELLS (CELLS),
      .AW    (AW),
      .CW    (CW)
   ) u_hole (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .cell_idx   (chk_idx_ff),
      .need       (need_ff),
      .pick_have  (pick_have),
      .pick_start (pick_start)
   );

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      op_in           = op_ff;
      owner_in        = owner_ff;
      need_in         = need_ff;
      chk_valid_in    = 1'b0;
      chk_last_in     = 1'b0;
      chk_idx_in      = cnt_ff[AW-1:0];
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_start_in    = rsp_start_ff;
      mem_re          = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = chk_idx_ff;
      mem_wdata       = '0;
      scan_clear      = 1'b0;

      // drop cells of the owner being cleared as they stream past
      if (chk_valid_ff && !chk_last_ff && op_ff == OP_CLEAR && mem_rdata == owner_ff) begin
         mem_we = 1'b1;
      end

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            if (cnt_ff == CW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               owner_in = owner_req;
               need_in  = len_ext[CW-1:0];
               cnt_in   = '0;
               if (owner_req == '0 || (req_op == OP_ALLOC && req_run_length == '0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_BAD;
                  rsp_start_in  = '0;
               end else if (req_op == OP_ALLOC && len_ext > 32'(CELLS)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NO_HOLE;
                  rsp_start_in  = '0;
               end else begin
                  scan_clear = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            chk_valid_in = 1'b1;
            if (cnt_ff == CW'(CELLS)) begin
               chk_last_in = 1'b1;
               state_in    = S_DRAIN;
            end else begin
               mem_re = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cnt_in = '0;
            if (op_ff == OP_CLEAR) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_DONE;
               rsp_start_in  = '0;
               state_in      = S_IDLE;
            end else if (pick_have) begin
               state_in = S_FILL;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_NO_HOLE;
               rsp_start_in  = '0;
               state_in      = S_IDLE;
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = pick_start + cnt_ff[AW-1:0];
            mem_wdata = owner_ff;
            if (cnt_ff == need_ff - CW'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_DONE;
               rsp_start_in  = start_ext[START_W-1:0];
               state_in      = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         chk_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         chk_last_ff  <= chk_last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_fit_policy;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      need_ff       <= need_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_cell = rsp_start_ff;

`ifndef NO_ASSERTIONS
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   a_fail_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_DONE) |-> (rsp_start_cell == '0))
      else $error("start cell not zero on failed request");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (cnt_ff < need_ff && pick_have))
      else $error("fill beyond requested length");

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE))
      else $error("response while sequencer active");
`endif

endmodule
